>>> rtl/adl32_pkg.sv
// Shared types, constants and modulo helpers for the Adler-32 checksum unit.
package adl32_pkg;

    // Item layout
    localparam int BYTES_PER_ITEM = 4;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 3;
    localparam int HALF_W         = 16;
    localparam int CSUM_W         = 2 * HALF_W;
    localparam int TDATA_BITS     = BYTE_W * BYTES_PER_ITEM + COUNT_W;
    localparam int TDATA_W        = ((TDATA_BITS + 7) / 8) * 8;

    // Adler modulus and derived accumulator widths
    localparam logic [HALF_W-1:0] ADLER_MOD = 16'd65521;
    localparam int MOD_MAX  = 65520;
    localparam int BYTE_MAX = 255;
    localparam int PROD_W   = BYTE_W + COUNT_W;
    localparam int BSUM_W   = $clog2(BYTE_MAX * BYTES_PER_ITEM + 1);
    localparam int WSUM_W   = $clog2(BYTE_MAX * BYTES_PER_ITEM * (BYTES_PER_ITEM + 1) / 2 + 1);
    localparam int HACC_W   = $clog2(MOD_MAX * (BYTES_PER_ITEM + 1)
                                     + BYTE_MAX * BYTES_PER_ITEM * (BYTES_PER_ITEM + 1) / 2 + 1);
    localparam int FOLD_HI_W = HACC_W - HALF_W;

    // Register map: word index taken from paddr[2]
    localparam int ADDR_W = 3;
    localparam logic REG_SEED = 1'b0;
    localparam logic [CSUM_W-1:0] SEED_RESET = 32'd1;

    // One lane's contribution
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [PROD_W-1:0] weighted;
    } lane_t;

    // Merged item waiting for the sum update
    typedef struct packed {
        logic               last;
        logic [COUNT_W-1:0] count;
        logic [BSUM_W-1:0]  byte_sum;
        logic [WSUM_W-1:0]  weight_sum;
    } stage_t;

    // One conditional subtract of the modulus (value below twice the modulus)
    function automatic logic [HALF_W-1:0] reduce_half(input logic [HALF_W:0] val);
        logic [HALF_W:0] diff;
        diff = val - {1'b0, ADLER_MOD};
        return (val >= {1'b0, ADLER_MOD}) ? diff[HALF_W-1:0] : val[HALF_W-1:0];
    endfunction

    // Fold the wide high-sum accumulator: 2^16 is 15 modulo 65521
    function automatic logic [HALF_W-1:0] fold_mod(input logic [HACC_W-1:0] val);
        logic [HALF_W:0] hi_ext;
        logic [HALF_W:0] folded;
        hi_ext = (HALF_W + 1)'(val[HACC_W-1:HALF_W]);
        folded = {1'b0, val[HALF_W-1:0]} + (hi_ext << 4) - hi_ext;
        return reduce_half(folded);
    endfunction

endpackage

>>> rtl/adl32_lane.sv
// One byte lane: masks the byte by the item's count and weights it for the high sum.
module adl32_lane (
    input  logic [adl32_pkg::BYTE_W-1:0]  data_byte,
    input  logic [adl32_pkg::COUNT_W-1:0] lane_idx,
    input  logic [adl32_pkg::COUNT_W-1:0] count,
    output adl32_pkg::lane_t              lane
);

    logic                              active;
    logic [adl32_pkg::COUNT_W-1:0]     weight;
    logic [adl32_pkg::PROD_W-1:0]      product;

    // Byte i enters the high sum once per byte from i to the end of the item
    assign active  = (lane_idx < count);
    assign weight  = count - lane_idx;
    assign product = adl32_pkg::PROD_W'(data_byte) * adl32_pkg::PROD_W'(weight);

    assign lane.data_byte = active ? data_byte : '0;
    assign lane.weighted  = active ? product : '0;

endmodule

>>> rtl/adl32_merge.sv
// Merge stage: adds the lane results and holds the item for the sum update.
module adl32_merge (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic                                            in_last,
    input  logic [adl32_pkg::COUNT_W-1:0]                   in_count,
    input  adl32_pkg::lane_t [adl32_pkg::BYTES_PER_ITEM-1:0] lanes,
    input  logic                                            take,
    output logic                                            stage_valid,
    output adl32_pkg::stage_t                               stage
);

    logic              valid_reg;
    logic              valid_next;
    adl32_pkg::stage_t stage_reg;
    adl32_pkg::stage_t stage_next;
    logic              load;

    // Stage frees up when empty or when its item moves on this cycle
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    // Lane sums
    always_comb
    begin
        stage_next.last       = in_last;
        stage_next.count      = in_count;
        stage_next.byte_sum   = '0;
        stage_next.weight_sum = '0;
        for (int i = 0; i < adl32_pkg::BYTES_PER_ITEM; i++)
        begin
            stage_next.byte_sum   = stage_next.byte_sum
                                    + adl32_pkg::BSUM_W'(lanes[i].data_byte);
            stage_next.weight_sum = stage_next.weight_sum
                                    + adl32_pkg::WSUM_W'(lanes[i].weighted);
        end
    end

    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

>>> rtl/adl32_accum.sv
// Running low and high sums, seed reload and the output register.
module adl32_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                stage_valid,
    input  adl32_pkg::stage_t                   stage,
    output logic                                take,
    input  logic                                seed_wr,
    input  logic [adl32_pkg::CSUM_W-1:0]        seed_wdata,
    input  logic [adl32_pkg::CSUM_W-1:0]        seed_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [adl32_pkg::CSUM_W-1:0]        out_data
);

    localparam int HW = adl32_pkg::HALF_W;

    logic [HW-1:0]                    sum_low_reg;
    logic [HW-1:0]                    sum_low_next;
    logic [HW-1:0]                    sum_high_reg;
    logic [HW-1:0]                    sum_high_next;
    logic [HW-1:0]                    low_upd;
    logic [HW-1:0]                    high_upd;
    logic [HW:0]                      low_acc;
    logic [adl32_pkg::HACC_W-1:0]     high_acc;
    logic [adl32_pkg::CSUM_W-1:0]     seed_src;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [adl32_pkg::CSUM_W-1:0]     out_data_reg;
    logic                             emit;

    // A last item waits only while the output register is still full
    assign take = stage_valid && !(stage.last && out_valid_reg && !out_ready);
    assign emit = take && stage.last;

    // Sum update for up to four bytes at once
    assign low_acc  = {1'b0, sum_low_reg} + (HW + 1)'(stage.byte_sum);
    assign high_acc = adl32_pkg::HACC_W'(sum_high_reg)
                      + adl32_pkg::HACC_W'(sum_low_reg) * adl32_pkg::HACC_W'(stage.count)
                      + adl32_pkg::HACC_W'(stage.weight_sum);
    assign low_upd  = adl32_pkg::reduce_half(low_acc);
    assign high_upd = adl32_pkg::fold_mod(high_acc);

    // Reload source: a fresh write wins over the stored seed
    assign seed_src = seed_wr ? seed_wdata : seed_value;

    always_comb
    begin
        priority if (seed_wr || emit)
        begin
            sum_low_next  = adl32_pkg::reduce_half({1'b0, seed_src[HW-1:0]});
            sum_high_next = adl32_pkg::reduce_half({1'b0, seed_src[2*HW-1:HW]});
        end
        else if (take)
        begin
            sum_low_next  = low_upd;
            sum_high_next = high_upd;
        end
        else
        begin
            sum_low_next  = sum_low_reg;
            sum_high_next = sum_high_reg;
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Sums and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg   <= adl32_pkg::SEED_RESET[HW-1:0];
            sum_high_reg  <= adl32_pkg::SEED_RESET[2*HW-1:HW];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_low_reg   <= sum_low_next;
            sum_high_reg  <= sum_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {high_upd, low_upd};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/adler32_checksum_unit.sv
// Top level of the Adler-32 checksum unit.
//
// Input stream (s_*): one item per handshake carries up to four message bytes,
// byte_0 first, plus a byte count; s_tlast marks the final item of a message.
// Output stream (m_*): one 32-bit checksum {high sum, low sum} per message.
// APB port: register 0 (byte address 0) is the seed; writing it reloads both
// sums, each half reduced modulo 65521. Write only while the unit is idle.
// Throughput: one item per clock, any count from 0 to 4 bytes, while no last
// item waits on a stalled checksum. The four byte lanes and the merge adder
// work in the first stage; the sum update (multiply by count, fold, one
// subtract) sets the clock budget and feeds the registered m_tdata output.
// Reset: seed becomes 1, sums 1 and 0, both stages empty, no result pending.
// Stall: while a checksum waits on m_tready, non-last items keep flowing; a
// further last item parks in the merge stage and s_tready drops only then.
module adler32_checksum_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte_0 [7:0], byte_1 [15:8], byte_2 [23:16], byte_3 [31:24],
    // valid_count [34:32], zero pad [39:35]
    input  logic [adl32_pkg::TDATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // checksum [31:0]
    output logic [adl32_pkg::CSUM_W-1:0]        m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adl32_pkg::ADDR_W-1:0]        paddr,
    input  logic [adl32_pkg::CSUM_W-1:0]        pwdata,
    output logic [adl32_pkg::CSUM_W-1:0]        prdata,
    output logic                                pready
);

    localparam int NB   = adl32_pkg::BYTES_PER_ITEM;
    localparam int BW   = adl32_pkg::BYTE_W;
    localparam int CW   = adl32_pkg::COUNT_W;

    logic [CW-1:0]                  raw_count;
    logic [CW-1:0]                  count_sat;
    adl32_pkg::lane_t [NB-1:0]      lanes;
    logic                           stage_valid;
    adl32_pkg::stage_t              stage;
    logic                           take;
    logic                           seed_wr;
    logic [adl32_pkg::CSUM_W-1:0]   seed_reg;

    // Count above the lane count saturates
    assign raw_count = s_tdata[NB*BW +: CW];
    assign count_sat = (raw_count > CW'(NB)) ? CW'(NB) : raw_count;

    // Byte lanes
    for (genvar i = 0; i < NB; i++)
    begin : g_lane
        adl32_lane u_lane (
            .data_byte (s_tdata[i*BW +: BW]),
            .lane_idx  (CW'(i)),
            .count     (count_sat),
            .lane      (lanes[i])
        );
    end

    adl32_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_last     (s_tlast),
        .in_count    (count_sat),
        .lanes       (lanes),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    adl32_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .take        (take),
        .seed_wr     (seed_wr),
        .seed_wdata  (pwdata),
        .seed_value  (seed_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

    // APB register access
    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && pready && (paddr[2] == adl32_pkg::REG_SEED);
    assign prdata  = (paddr[2] == adl32_pkg::REG_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= adl32_pkg::SEED_RESET;
        end
        else if (seed_wr)
        begin
            seed_reg <= pwdata;
        end
    end

endmodule

>>> rtl/adl32_checker.sv
// Port-level checks for the Adler-32 checksum unit, bound to the top level.
module adl32_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic [adl32_pkg::CSUM_W-1:0]        m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adl32_pkg::ADDR_W-1:0]        paddr,
    input  logic [adl32_pkg::CSUM_W-1:0]        pwdata,
    input  logic [adl32_pkg::CSUM_W-1:0]        prdata
);

    // A stalled checksum holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("checksum changed while stalled");

    // Both halves of a checksum are fully reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] < adl32_pkg::ADLER_MOD)
                     && (m_tdata[31:16] < adl32_pkg::ADLER_MOD))
    else $error("checksum half not reduced");

    // Input side never stalls unless a checksum is stuck at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled without output backpressure");

    // Seed reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == adl32_pkg::REG_SEED)
        |=> (paddr[2] != adl32_pkg::REG_SEED) || (prdata == $past(pwdata)))
    else $error("seed readback mismatch");

endmodule

bind adler32_checksum_unit adl32_checker u_adl32_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
